/* design/xorwow_random_with_modulo_top_assert.svh */
// Assertion macros shared by the xorwow checker.
`ifndef XORWOW_RANDOM_WITH_MODULO_TOP_ASSERT_SVH
`define XORWOW_RANDOM_WITH_MODULO_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define XRM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define XRM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/xrm_pkg.sv */
// Package for the xorwow generator: widths, constants, state type, word update.
`default_nettype none

package xrm_pkg;

  localparam int DATA_W     = 32;
  localparam int WORD_COUNT = 5;
  localparam int CNT_W      = $clog2(DATA_W);

  localparam logic [DATA_W-1:0] DEFAULT_SEED = 32'd2147483629;
  localparam logic [DATA_W-1:0] WEYL_STEP    = 32'd362437;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN
  } state_t;

  // xorshift mix of the oldest word t with the newest word s
  function automatic logic [DATA_W-1:0] xs_mix(input logic [DATA_W-1:0] t,
                                                input logic [DATA_W-1:0] s);
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    a = t ^ (t >> 2);
    b = a ^ (a << 1);
    return b ^ s ^ (s << 4);
  endfunction

endpackage

`default_nettype wire

/* design/xrm_cfg_if.sv */
// Seed write channel.
`default_nettype none

interface xrm_cfg_if;
  import xrm_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] seed;

  modport source (output valid, output seed, input ready);
  modport sink   (input valid, input seed, output ready);
endinterface

`default_nettype wire

/* design/xrm_req_if.sv */
// Request channel: one item carries a bound.
`default_nettype none

interface xrm_req_if;
  import xrm_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] bound;

  modport source (output valid, output bound, input ready);
  modport sink   (input valid, input bound, output ready);
endinterface

`default_nettype wire

/* design/xrm_rsp_if.sv */
// Result channel: one item carries a random value.
`default_nettype none

interface xrm_rsp_if;
  import xrm_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

/* design/xorwow_random_with_modulo_top.sv */
// With a nonzero bound the raw value is formed at accept, then the bit-serial loop runs
// 32 restoring remainder steps of one bit, then a finish state loads the result register;
// a zero bound goes straight to the finish state. One request in flight: no new request
// is taken until the finish state has loaded its result, which waits while an earlier
// result is not taken. The output register lets the next request start while a result
// waits. Reset (synchronous) loads the default seed; no clear pass.
`default_nettype none

module xorwow_random_with_modulo_top (
  input  wire logic clk,
  input  wire logic rst,
  xrm_cfg_if.sink   cfg,
  xrm_req_if.sink   req,
  xrm_rsp_if.source rsp
);
  import xrm_pkg::*;

  // Generator state; weyl holds the counter value of the next request
  logic [DATA_W-1:0] words [WORD_COUNT];
  logic [DATA_W-1:0] weyl;

  // Remainder datapath
  logic [DATA_W-1:0] bnd;
  logic [DATA_W-1:0] dvd;
  logic [DATA_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;

  // Result register
  logic              out_valid;
  logic [DATA_W-1:0] out_value;

  state_t state, state_next;

  logic              req_take;
  logic              cfg_take;
  logic              rsp_load;
  logic [DATA_W-1:0] mixed;
  logic [DATA_W-1:0] raw;
  logic [DATA_W-1:0] seed_base;
  logic [DATA_W:0]   part;
  logic [DATA_W+1:0] diff;
  logic [DATA_W-1:0] rem_next;
  logic              last_step;

  // Handshakes
  assign req_take  = req.valid && req.ready;
  assign cfg_take  = cfg.valid && cfg.ready;
  assign last_step = (cnt == CNT_W'(DATA_W - 1));

  // Word update and raw value
  assign mixed     = xs_mix(words[WORD_COUNT-1], words[0]);
  assign raw       = mixed + weyl;
  assign seed_base = (cfg.seed == '0) ? DEFAULT_SEED : cfg.seed;

  // One restoring remainder step: bring in the next dividend bit
  assign part = {rem, dvd[DATA_W-1]};
  assign diff = {1'b0, part} - {2'b00, bnd};
  always_comb begin
    if (diff[DATA_W+1]) begin
      rem_next = part[DATA_W-1:0];
    end else begin
      rem_next = diff[DATA_W-1:0];
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_take) begin
          state_next = (req.bound == '0) ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        if (last_step) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    req.ready = 1'b0;
    rsp_load  = 1'b0;
    unique case (state)
      ST_IDLE: req.ready = 1'b1;
      ST_DIV:  ;
      ST_FIN:  rsp_load = !out_valid || rsp.ready;
      default: ;
    endcase
  end

  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.value = out_value;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Generator words and counter: load on reset or seed write, advance on request
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WORD_COUNT; i++) begin
        words[i] <= DEFAULT_SEED + DATA_W'(i);
      end
      weyl <= WEYL_STEP;
    end else if (cfg_take) begin
      for (int i = 0; i < WORD_COUNT; i++) begin
        words[i] <= seed_base + DATA_W'(i);
      end
      weyl <= WEYL_STEP;
    end else if (req_take) begin
      for (int i = 1; i < WORD_COUNT; i++) begin
        words[i] <= words[i-1];
      end
      words[0] <= mixed;
      weyl     <= weyl + WEYL_STEP;
    end
  end

  // Remainder shift registers
  always_ff @(posedge clk) begin
    if (req_take) begin
      bnd <= req.bound;
      dvd <= raw;
      rem <= '0;
      cnt <= '0;
    end else if (state == ST_DIV) begin
      dvd <= dvd << 1;
      rem <= rem_next;
      cnt <= cnt + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rsp_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      out_value <= (bnd == '0) ? dvd : rem;
    end
  end

endmodule

`default_nettype wire

/* design/xrm_checker.sv */
// Port-level checker for the xorwow generator, bound to the top level.
`default_nettype none

`include "xorwow_random_with_modulo_top_assert.svh"

module xrm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [31:0] rsp_value
);
  logic       req_take;
  logic       rsp_take;
  logic [1:0] pending;

  assign req_take = req_valid && req_ready;
  assign rsp_take = rsp_valid && rsp_ready;

  // Items accepted whose result has not been taken yet
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, req_take} - {1'b0, rsp_take};
    end
  end

  `XRM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value), "result changed while stalled")
  `XRM_ASSERT_NEXT(a_one_in_flight, req_take, !req_ready, "request accepted while another is in work")
  `XRM_ASSERT_NOW(a_no_spurious, rsp_valid, pending != 2'd0, "result without an outstanding item")
  `XRM_ASSERT_NOW(a_pending_cap, 1'b1, pending != 2'd3, "more than two items outstanding")

endmodule

bind xorwow_random_with_modulo_top xrm_checker u_xrm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_value (rsp.value)
);

`default_nettype wire
